>>> design/dkt_pkg.sv
// Shared types and constants for the debounced key toggle bank.
package dkt_pkg;

  localparam int CH_W  = 6;
  localparam int CNT_W = 4;
  localparam int ENA_W = 64;
  localparam int CFG_IDX_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ENABLE    = 8'd1;

  localparam logic FUNC_SAMPLE = 1'b0;
  localparam logic FUNC_REMOTE = 1'b1;

  localparam logic LVL_PRESSED  = 1'b0;
  localparam logic LVL_RELEASED = 1'b1;

  localparam logic [CNT_W-1:0] THRESHOLD_RST = 4'd3;

  typedef struct packed {
    logic            func;
    logic [CH_W-1:0] channel;
    logic            level;
  } in_item_t;

  typedef struct packed {
    logic [CH_W-1:0] event_channel;
    logic            event_state;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic             toggle;
    logic             latch;
  } chan_state_t;

  localparam int STATE_W = $bits(chan_state_t);

  typedef struct packed {
    chan_state_t state;
    logic        evt;
  } upd_t;

endpackage

>>> design/dkt_ram.sv
// Generic single-write, single-read RAM with registered read data.
module dkt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/dkt_chan_update.sv
// Per-channel debounce, toggle and latch update for one item.
module dkt_chan_update (
  input  dkt_pkg::chan_state_t          cur,
  input  dkt_pkg::in_item_t             item,
  input  logic [dkt_pkg::CNT_W-1:0]     threshold,
  output dkt_pkg::upd_t                 upd
);

  logic held;

  assign held = (cur.count >= threshold);

  always_comb begin
    upd.state = cur;
    upd.evt   = 1'b0;
    if (item.func == dkt_pkg::FUNC_REMOTE) begin
      upd.state.toggle = item.level;
      upd.state.latch  = held ? ~item.level : item.level;
    end else if (item.level == dkt_pkg::LVL_RELEASED) begin
      upd.state.count = '0;
      upd.state.latch = cur.toggle;
    end else if (!held) begin
      upd.state.count = cur.count + dkt_pkg::CNT_W'(1);
    end else if (cur.latch == cur.toggle) begin
      upd.state.toggle = ~cur.toggle;
      upd.evt          = 1'b1;
    end
  end

endmodule

>>> design/debounced_key_toggle_bank.sv
// Top level of the debounced key toggle bank.
//
// Input channel (in_valid/in_stall/in_data): one beat per key sample or
// remote set, addressed to a channel. Result channel (out_valid/out_stall/
// out_data): one beat per key-sample toggle flip, giving the channel and its new state.
// Config port (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 sets the
// debounce threshold, index 1 the channel enable mask; always ready. The user
// must write it only while the bank is idle; the block does not enforce this.
// The accepting edge registers the item and reads the channel state RAM; when
// the update stage advances, the updated state is written back and the result
// register loaded, with a bypass for back-to-back beats on the same channel.
// Throughput: one beat per cycle while out_stall is low.
// Reset: all channel state reads as zero through per-entry valid bits, the
// threshold returns to 3 and all channels are disabled. No clearing pass.
// Stall: while a result waits under out_stall, the beat in the update stage
// holds and in_stall rises; nothing is dropped.
module debounced_key_toggle_bank #(
  parameter int NUM_CHANNELS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  dkt_pkg::in_item_t               in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output dkt_pkg::out_item_t              out_data,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dkt_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [dkt_pkg::ENA_W-1:0]       cfg_data
);

  localparam int AW = $clog2(NUM_CHANNELS);

  logic [dkt_pkg::CNT_W-1:0] thr_r;
  logic [dkt_pkg::ENA_W-1:0] ena_r;

  logic                   s1_valid_r;
  dkt_pkg::in_item_t      s1_item_r;
  logic                   vld_rd_r;
  logic [NUM_CHANNELS-1:0] ent_vld_r;

  logic                   byp_valid_r;
  logic [AW-1:0]          byp_addr_r;
  dkt_pkg::chan_state_t   byp_state_r;

  logic                   out_valid_r;
  dkt_pkg::out_item_t     out_data_r;

  logic                   in_accept;
  logic                   adv;
  logic [AW-1:0]          rd_addr;
  logic [AW-1:0]          s1_addr;
  logic [dkt_pkg::STATE_W-1:0] ram_rdata;
  logic                   in_rng;
  logic                   live;
  logic                   wr_en;
  dkt_pkg::chan_state_t   cur;
  dkt_pkg::upd_t          upd;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign adv       = !out_valid_r || !out_stall;
  assign in_stall  = s1_valid_r && !adv;
  assign rd_addr   = in_data.channel[AW-1:0];
  assign s1_addr   = s1_item_r.channel[AW-1:0];
  assign in_rng    = ({1'b0, s1_item_r.channel} < (dkt_pkg::CH_W+1)'(NUM_CHANNELS));
  assign live      = s1_valid_r && in_rng && ena_r[s1_item_r.channel];
  assign wr_en     = live && adv;

  always_comb begin
    if (byp_valid_r && (byp_addr_r == s1_addr)) begin
      cur = byp_state_r;
    end else if (vld_rd_r) begin
      cur = dkt_pkg::chan_state_t'(ram_rdata);
    end else begin
      cur = '0;
    end
  end

  dkt_ram #(
    .WIDTH(dkt_pkg::STATE_W),
    .DEPTH(NUM_CHANNELS)
  ) u_ram (
    .clk    (clk),
    .wr_en  (wr_en),
    .wr_addr(s1_addr),
    .wr_data(upd.state),
    .rd_en  (in_accept),
    .rd_addr(rd_addr),
    .rd_data(ram_rdata)
  );

  dkt_chan_update u_upd (
    .cur      (cur),
    .item     (s1_item_r),
    .threshold(thr_r),
    .upd      (upd)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= dkt_pkg::THRESHOLD_RST;
      ena_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dkt_pkg::CFG_THRESHOLD: thr_r <= cfg_data[dkt_pkg::CNT_W-1:0];
        dkt_pkg::CFG_ENABLE:    ena_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      ent_vld_r   <= '0;
      byp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_r <= 1'b1;
      end else if (adv) begin
        s1_valid_r <= 1'b0;
      end
      if (wr_en) begin
        ent_vld_r[s1_addr] <= 1'b1;
        byp_valid_r        <= 1'b1;
      end
      if (adv) begin
        out_valid_r <= live && upd.evt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_item_r <= in_data;
      vld_rd_r  <= ent_vld_r[rd_addr];
    end
    if (wr_en) begin
      byp_addr_r  <= s1_addr;
      byp_state_r <= upd.state;
    end
    if (adv) begin
      out_data_r <= '{event_channel: s1_item_r.channel, event_state: upd.state.toggle};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> design/dkt_checker.sv
// Port-level checks for the debounced key toggle bank, bound to the top level.
module dkt_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_valid,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input dkt_pkg::out_item_t            out_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result beat changed under stall");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall, 2))
    else $error("result beat without an input beat two cycles before");

  a_no_idle_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty result register");

endmodule

bind debounced_key_toggle_bank dkt_checker u_dkt_checker (.*);
